FILE: hw/rtl/hbs_pkg.sv
// Shared constants, types and the friction lookup for the heightmap sampler.
package hbs_pkg;

    localparam int GRID_SIDE_DEF = 65;
    localparam int CELL_INDEX_W  = 13;
    localparam int ELEV_W        = 32;
    localparam int CLASS_W       = 8;
    localparam int FRIC_W        = 7;
    localparam int FRAC_W        = 16;
    localparam int COORD_W       = 32;
    localparam int ONE_Q16       = 65536;

    localparam logic       CMD_WRITE  = 1'b0;
    localparam logic       CMD_SAMPLE = 1'b1;

    localparam logic [CLASS_W-1:0] CLASS_PAVED  = 8'd0;
    localparam logic [CLASS_W-1:0] CLASS_GRAVEL = 8'd1;
    localparam logic [CLASS_W-1:0] CLASS_DIRT   = 8'd2;
    localparam logic [CLASS_W-1:0] CLASS_MUD    = 8'd3;

    localparam logic [FRIC_W-1:0] FRIC_DRY_PAVED  = 7'd85;
    localparam logic [FRIC_W-1:0] FRIC_DRY_GRAVEL = 7'd80;
    localparam logic [FRIC_W-1:0] FRIC_DRY_DIRT   = 7'd55;
    localparam logic [FRIC_W-1:0] FRIC_DRY_MUD    = 7'd28;
    localparam logic [FRIC_W-1:0] FRIC_DRY_OTHER  = 7'd80;
    localparam logic [FRIC_W-1:0] FRIC_WET_PAVED  = 7'd55;
    localparam logic [FRIC_W-1:0] FRIC_WET_GRAVEL = 7'd48;
    localparam logic [FRIC_W-1:0] FRIC_WET_DIRT   = 7'd25;
    localparam logic [FRIC_W-1:0] FRIC_WET_MUD    = 7'd18;
    localparam logic [FRIC_W-1:0] FRIC_WET_OTHER  = 7'd48;

    typedef struct packed {
        logic valid;
        logic wet;
    } hbs_ctl_t;

    function automatic logic [FRIC_W-1:0] friction_of(input logic [CLASS_W-1:0] cls,
                                                      input logic wet);
        logic [FRIC_W-1:0] f;
        case (cls)
            CLASS_PAVED:  f = wet ? FRIC_WET_PAVED  : FRIC_DRY_PAVED;
            CLASS_GRAVEL: f = wet ? FRIC_WET_GRAVEL : FRIC_DRY_GRAVEL;
            CLASS_DIRT:   f = wet ? FRIC_WET_DIRT   : FRIC_DRY_DIRT;
            CLASS_MUD:    f = wet ? FRIC_WET_MUD    : FRIC_DRY_MUD;
            default:      f = wet ? FRIC_WET_OTHER  : FRIC_DRY_OTHER;
        endcase
        return f;
    endfunction

endpackage

FILE: hw/rtl/heightmap_bilinear_sampler.sv
// Top level of the heightmap sampler: grid stores and the sampling pipeline.
//
// Usage: a command word is taken at a rising edge where start is high and
// busy is low. With cmd low the word writes one grid cell (elevation and
// class) at cell_index; an index beyond the grid is dropped. With cmd high
// the word samples the grid at query_x and query_z.
// Busy is always low, so one word is taken every cycle, writes and samples
// mixed freely. A sample that follows a write in the next cycle sees it.
// Each sample gives one result word: done is high for exactly one cycle,
// after the address, read and blend stages, with elevation, surface_class
// and friction valid in that cycle. Writes give no result word.
// Throughput is one word per cycle. The four corner reads come from two
// copies of the grid store, each with two read ports, so no read contends.
// The receiver cannot hold results off and nothing in the block waits.
// Reset clears all pipeline valid bits; the grid contents are not cleared
// and a cell must be written before a sample touches it.
module heightmap_bilinear_sampler #(
    parameter int GRID_SIDE = hbs_pkg::GRID_SIDE_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                cmd,
    input  logic [hbs_pkg::CELL_INDEX_W-1:0]    cell_index,
    input  logic signed [hbs_pkg::ELEV_W-1:0]   cell_elevation,
    input  logic [hbs_pkg::CLASS_W-1:0]         cell_class,
    input  logic signed [hbs_pkg::COORD_W-1:0]  query_x,
    input  logic signed [hbs_pkg::COORD_W-1:0]  query_z,
    input  logic                                wet,
    output logic                                done,
    output logic signed [hbs_pkg::ELEV_W-1:0]   elevation,
    output logic [hbs_pkg::CLASS_W-1:0]         surface_class,
    output logic [hbs_pkg::FRIC_W-1:0]          friction
);

    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(CELLS);
    localparam int EW    = hbs_pkg::ELEV_W;
    localparam int CW    = hbs_pkg::CLASS_W;
    localparam int WW    = EW + CW;
    localparam int FW    = hbs_pkg::FRAC_W;

    logic              we;
    logic [AW-1:0]     waddr;
    logic [WW-1:0]     wdata;
    logic [AW-1:0]     addr00, addr01, addr10, addr11;
    logic [FW-1:0]     fx, fz;
    hbs_pkg::hbs_ctl_t ctl;
    logic [WW-1:0]     rd00, rd01, rd10, rd11;

    logic              s3_valid_reg;
    logic              s3_wet_reg;
    hbs_pkg::hbs_ctl_t s3_ctl;
    logic [FW-1:0]     s3_fx_reg;
    logic [FW-1:0]     s3_fz_reg;

    assign busy = 1'b0;

    hbs_addr #(
        .GRID_SIDE (GRID_SIDE),
        .AW        (AW)
    ) u_addr (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start && !busy),
        .cmd            (cmd),
        .cell_index     (cell_index),
        .cell_elevation (cell_elevation),
        .cell_class     (cell_class),
        .query_x        (query_x),
        .query_z        (query_z),
        .wet            (wet),
        .we             (we),
        .waddr          (waddr),
        .wdata          (wdata),
        .addr00         (addr00),
        .addr01         (addr01),
        .addr10         (addr10),
        .addr11         (addr11),
        .fx             (fx),
        .fz             (fz),
        .ctl            (ctl)
    );

    hbs_ram #(
        .WIDTH (WW),
        .DEPTH (CELLS)
    ) u_ram_row0 (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (addr00),
        .raddr_b (addr01),
        .rdata_a (rd00),
        .rdata_b (rd01)
    );

    hbs_ram #(
        .WIDTH (WW),
        .DEPTH (CELLS)
    ) u_ram_row1 (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (addr10),
        .raddr_b (addr11),
        .rdata_a (rd10),
        .rdata_b (rd11)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_wet_reg <= ctl.wet;
        s3_fx_reg  <= fx;
        s3_fz_reg  <= fz;
    end

    assign s3_ctl = '{valid: s3_valid_reg, wet: s3_wet_reg};

    hbs_blend u_blend (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (s3_ctl),
        .e00           (rd00[WW-1:CW]),
        .e01           (rd01[WW-1:CW]),
        .e10           (rd10[WW-1:CW]),
        .e11           (rd11[WW-1:CW]),
        .c00           (rd00[CW-1:0]),
        .c01           (rd01[CW-1:0]),
        .c10           (rd10[CW-1:0]),
        .c11           (rd11[CW-1:0]),
        .fx            (s3_fx_reg),
        .fz            (s3_fz_reg),
        .done          (done),
        .elevation     (elevation),
        .surface_class (surface_class),
        .friction      (friction)
    );

    a_sample_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd == hbs_pkg::CMD_SAMPLE) |-> ##7 done)
        else $error("sample word produced no result");

    a_result_has_sample: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy && cmd == hbs_pkg::CMD_SAMPLE, 7))
        else $error("result word without a matching sample");

    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd == hbs_pkg::CMD_WRITE) |-> ##7 !done)
        else $error("write word produced a result");

    a_friction_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (friction >= 7'd18 && friction <= 7'd85))
        else $error("friction out of table range");

endmodule

FILE: hw/rtl/hbs_ram.sv
// Generic RAM with one write port and two registered read ports.
module hbs_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 4225
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a_reg <= mem_reg[raddr_a];
        rdata_b_reg <= mem_reg[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

FILE: hw/rtl/hbs_addr.sv
// Coordinate clamp and scale, corner address generation and write decode.
module hbs_addr #(
    parameter int GRID_SIDE = hbs_pkg::GRID_SIDE_DEF,
    parameter int AW        = $clog2(GRID_SIDE * GRID_SIDE)
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic                                   cmd,
    input  logic [hbs_pkg::CELL_INDEX_W-1:0]       cell_index,
    input  logic signed [hbs_pkg::ELEV_W-1:0]      cell_elevation,
    input  logic [hbs_pkg::CLASS_W-1:0]            cell_class,
    input  logic signed [hbs_pkg::COORD_W-1:0]     query_x,
    input  logic signed [hbs_pkg::COORD_W-1:0]     query_z,
    input  logic                                   wet,
    output logic                                   we,
    output logic [AW-1:0]                          waddr,
    output logic [hbs_pkg::ELEV_W+hbs_pkg::CLASS_W-1:0] wdata,
    output logic [AW-1:0]                          addr00,
    output logic [AW-1:0]                          addr01,
    output logic [AW-1:0]                          addr10,
    output logic [AW-1:0]                          addr11,
    output logic [hbs_pkg::FRAC_W-1:0]             fx,
    output logic [hbs_pkg::FRAC_W-1:0]             fz,
    output hbs_pkg::hbs_ctl_t                      ctl
);

    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int IW    = $clog2(GRID_SIDE);
    localparam int FW    = hbs_pkg::FRAC_W;
    localparam int GW    = FW + IW;
    localparam int WW    = hbs_pkg::ELEV_W + hbs_pkg::CLASS_W;

    function automatic logic [FW:0] clamp_q(input logic signed [hbs_pkg::COORD_W-1:0] q);
        logic [FW:0] c;
        if (q < 0)
        begin
            c = '0;
        end
        else if (q > hbs_pkg::COORD_W'(hbs_pkg::ONE_Q16))
        begin
            c = (FW+1)'(hbs_pkg::ONE_Q16);
        end
        else
        begin
            c = q[FW:0];
        end
        return c;
    endfunction

    logic            s1_valid_reg, s1_valid_next;
    logic            s1_wr_reg, s1_wr_next;
    logic [GW-1:0]   s1_gx_reg, s1_gx_next;
    logic [GW-1:0]   s1_gz_reg, s1_gz_next;
    logic            s1_wet_reg;
    logic [AW-1:0]   s1_idx_reg;
    logic [WW-1:0]   s1_wdata_reg;

    logic            s2_valid_reg, s2_valid_next;
    logic            s2_wr_reg, s2_wr_next;
    logic            s2_wet_reg;
    logic [AW-1:0]   s2_waddr_reg;
    logic [WW-1:0]   s2_wdata_reg;
    logic [AW-1:0]   s2_a00_reg, s2_a00_next;
    logic [AW-1:0]   s2_a01_reg, s2_a01_next;
    logic [AW-1:0]   s2_a10_reg, s2_a10_next;
    logic [AW-1:0]   s2_a11_reg, s2_a11_next;
    logic [FW-1:0]   s2_fx_reg;
    logic [FW-1:0]   s2_fz_reg;

    logic [IW-1:0]   x0, x1, z0, z1;

    always_comb
    begin
        s1_valid_next = start && (cmd == hbs_pkg::CMD_SAMPLE);
        s1_wr_next    = start && (cmd == hbs_pkg::CMD_WRITE) &&
                        (32'(cell_index) < 32'(CELLS));
        s1_gx_next    = GW'(clamp_q(query_x) * GW'(GRID_SIDE - 1));
        s1_gz_next    = GW'(clamp_q(query_z) * GW'(GRID_SIDE - 1));
    end

    always_comb
    begin
        x0 = s1_gx_reg[GW-1:FW];
        z0 = s1_gz_reg[GW-1:FW];
        x1 = (x0 == IW'(GRID_SIDE - 1)) ? x0 : x0 + IW'(1);
        z1 = (z0 == IW'(GRID_SIDE - 1)) ? z0 : z0 + IW'(1);
        s2_a00_next   = AW'(z0) * AW'(GRID_SIDE) + AW'(x0);
        s2_a01_next   = AW'(z0) * AW'(GRID_SIDE) + AW'(x1);
        s2_a10_next   = AW'(z1) * AW'(GRID_SIDE) + AW'(x0);
        s2_a11_next   = AW'(z1) * AW'(GRID_SIDE) + AW'(x1);
        s2_valid_next = s1_valid_reg;
        s2_wr_next    = s1_wr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_wr_reg    <= 1'b0;
            s2_valid_reg <= 1'b0;
            s2_wr_reg    <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s1_wr_reg    <= s1_wr_next;
            s2_valid_reg <= s2_valid_next;
            s2_wr_reg    <= s2_wr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_gx_reg    <= s1_gx_next;
        s1_gz_reg    <= s1_gz_next;
        s1_wet_reg   <= wet;
        s1_idx_reg   <= AW'(cell_index);
        s1_wdata_reg <= {cell_elevation, cell_class};
        s2_wet_reg   <= s1_wet_reg;
        s2_waddr_reg <= s1_idx_reg;
        s2_wdata_reg <= s1_wdata_reg;
        s2_a00_reg   <= s2_a00_next;
        s2_a01_reg   <= s2_a01_next;
        s2_a10_reg   <= s2_a10_next;
        s2_a11_reg   <= s2_a11_next;
        s2_fx_reg    <= s1_gx_reg[FW-1:0];
        s2_fz_reg    <= s1_gz_reg[FW-1:0];
    end

    assign we        = s2_wr_reg;
    assign waddr     = s2_waddr_reg;
    assign wdata     = s2_wdata_reg;
    assign addr00    = s2_a00_reg;
    assign addr01    = s2_a01_reg;
    assign addr10    = s2_a10_reg;
    assign addr11    = s2_a11_reg;
    assign fx        = s2_fx_reg;
    assign fz        = s2_fz_reg;
    assign ctl       = '{valid: s2_valid_reg, wet: s2_wet_reg};

endmodule

FILE: hw/rtl/hbs_blend.sv
// Bilinear blend pipeline with nearest-class select and friction lookup.
module hbs_blend (
    input  logic                                clk,
    input  logic                                rst_n,
    input  hbs_pkg::hbs_ctl_t                   ctl,
    input  logic signed [hbs_pkg::ELEV_W-1:0]   e00,
    input  logic signed [hbs_pkg::ELEV_W-1:0]   e01,
    input  logic signed [hbs_pkg::ELEV_W-1:0]   e10,
    input  logic signed [hbs_pkg::ELEV_W-1:0]   e11,
    input  logic [hbs_pkg::CLASS_W-1:0]         c00,
    input  logic [hbs_pkg::CLASS_W-1:0]         c01,
    input  logic [hbs_pkg::CLASS_W-1:0]         c10,
    input  logic [hbs_pkg::CLASS_W-1:0]         c11,
    input  logic [hbs_pkg::FRAC_W-1:0]          fx,
    input  logic [hbs_pkg::FRAC_W-1:0]          fz,
    output logic                                done,
    output logic signed [hbs_pkg::ELEV_W-1:0]   elevation,
    output logic [hbs_pkg::CLASS_W-1:0]         surface_class,
    output logic [hbs_pkg::FRIC_W-1:0]          friction
);

    localparam int EW = hbs_pkg::ELEV_W;
    localparam int FW = hbs_pkg::FRAC_W;
    localparam int PW = EW + 1 + FW + 1;

    logic                  s4_valid_reg, s5_valid_reg, s6_valid_reg, s7_valid_reg;
    logic                  s4_wet_reg;
    logic signed [EW-1:0]  s4_a0_reg, s4_a1_reg;
    logic signed [PW-1:0]  s4_p0_reg, s4_p0_next;
    logic signed [PW-1:0]  s4_p1_reg, s4_p1_next;
    logic [FW-1:0]         s4_fz_reg;
    logic [hbs_pkg::CLASS_W-1:0] s4_cls_reg, s4_cls_next;

    logic signed [EW-1:0]  s5_v0_reg, s5_v0_next;
    logic signed [EW-1:0]  s5_v1_reg, s5_v1_next;
    logic [FW-1:0]         s5_fz_reg;
    logic [hbs_pkg::CLASS_W-1:0] s5_cls_reg;
    logic [hbs_pkg::FRIC_W-1:0]  s5_fric_reg, s5_fric_next;

    logic signed [EW-1:0]  s6_v0_reg;
    logic signed [PW-1:0]  s6_p2_reg, s6_p2_next;
    logic [hbs_pkg::CLASS_W-1:0] s6_cls_reg;
    logic [hbs_pkg::FRIC_W-1:0]  s6_fric_reg;

    logic signed [EW-1:0]  s7_elev_reg, s7_elev_next;
    logic [hbs_pkg::CLASS_W-1:0] s7_cls_reg;
    logic [hbs_pkg::FRIC_W-1:0]  s7_fric_reg;

    logic signed [EW:0]    d0, d1, d2;

    always_comb
    begin
        d0         = {e01[EW-1], e01} - {e00[EW-1], e00};
        d1         = {e11[EW-1], e11} - {e10[EW-1], e10};
        s4_p0_next = d0 * $signed({1'b0, fx});
        s4_p1_next = d1 * $signed({1'b0, fx});
        if (fz[FW-1])
        begin
            s4_cls_next = fx[FW-1] ? c11 : c10;
        end
        else
        begin
            s4_cls_next = fx[FW-1] ? c01 : c00;
        end
    end

    always_comb
    begin
        s5_v0_next   = s4_a0_reg + s4_p0_reg[FW+EW-1:FW];
        s5_v1_next   = s4_a1_reg + s4_p1_reg[FW+EW-1:FW];
        s5_fric_next = hbs_pkg::friction_of(s4_cls_reg, s4_wet_reg);
    end

    always_comb
    begin
        d2           = {s5_v1_reg[EW-1], s5_v1_reg} - {s5_v0_reg[EW-1], s5_v0_reg};
        s6_p2_next   = d2 * $signed({1'b0, s5_fz_reg});
        s7_elev_next = s6_v0_reg + s6_p2_reg[FW+EW-1:FW];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= ctl.valid;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
            s7_valid_reg <= s6_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_wet_reg  <= ctl.wet;
        s4_a0_reg   <= e00;
        s4_a1_reg   <= e10;
        s4_p0_reg   <= s4_p0_next;
        s4_p1_reg   <= s4_p1_next;
        s4_fz_reg   <= fz;
        s4_cls_reg  <= s4_cls_next;
        s5_v0_reg   <= s5_v0_next;
        s5_v1_reg   <= s5_v1_next;
        s5_fz_reg   <= s4_fz_reg;
        s5_cls_reg  <= s4_cls_reg;
        s5_fric_reg <= s5_fric_next;
        s6_v0_reg   <= s5_v0_reg;
        s6_p2_reg   <= s6_p2_next;
        s6_cls_reg  <= s5_cls_reg;
        s6_fric_reg <= s5_fric_reg;
        s7_elev_reg <= s7_elev_next;
        s7_cls_reg  <= s6_cls_reg;
        s7_fric_reg <= s6_fric_reg;
    end

    assign done          = s7_valid_reg;
    assign elevation     = s7_elev_reg;
    assign surface_class = s7_cls_reg;
    assign friction      = s7_fric_reg;

endmodule

FILE: verif/heightmap_bilinear_sampler_tb.sv
// Self-checking testbench for the heightmap bilinear sampler with a scoreboard class.
module heightmap_bilinear_sampler_tb;

    localparam int SIDE  = hbs_pkg::GRID_SIDE_DEF;
    localparam int CELLS = SIDE * SIDE;
    localparam int STEP  = hbs_pkg::ONE_Q16 / (SIDE - 1);
    localparam int BAND  = 6;

    typedef struct {
        logic signed [hbs_pkg::ELEV_W-1:0] elev;
        logic [hbs_pkg::CLASS_W-1:0]       cls;
        logic [hbs_pkg::FRIC_W-1:0]        fric;
    } sample_t;

    class sample_scoreboard;
        logic signed [hbs_pkg::ELEV_W-1:0] elev_grid[CELLS];
        logic [hbs_pkg::CLASS_W-1:0]       class_grid[CELLS];
        sample_t                           pending_q[$];
        int                                errors = 0;

        function logic [31:0] grid_pos(logic signed [hbs_pkg::COORD_W-1:0] c);
            longint v;
            v = c;
            if (v < 0)
                v = 0;
            if (v > hbs_pkg::ONE_Q16)
                v = hbs_pkg::ONE_Q16;
            return 32'(v * (SIDE - 1));
        endfunction

        function longint lerp(longint a, longint b, logic [15:0] f);
            longint p;
            p = (b - a) * longint'({1'b0, f});
            return a + (p >>> 16);
        endfunction

        function longint height(int unsigned r, int unsigned c);
            return longint'(elev_grid[r * SIDE + c]);
        endfunction

        function int unsigned nearest(logic [31:0] g);
            int unsigned i;
            i = (g + 32'h8000) >> 16;
            return (i > SIDE - 1) ? SIDE - 1 : i;
        endfunction

        function logic [hbs_pkg::FRIC_W-1:0] grip(logic [hbs_pkg::CLASS_W-1:0] c, logic w);
            case (c)
                hbs_pkg::CLASS_PAVED:
                    return w ? hbs_pkg::FRIC_WET_PAVED  : hbs_pkg::FRIC_DRY_PAVED;
                hbs_pkg::CLASS_GRAVEL:
                    return w ? hbs_pkg::FRIC_WET_GRAVEL : hbs_pkg::FRIC_DRY_GRAVEL;
                hbs_pkg::CLASS_DIRT:
                    return w ? hbs_pkg::FRIC_WET_DIRT   : hbs_pkg::FRIC_DRY_DIRT;
                hbs_pkg::CLASS_MUD:
                    return w ? hbs_pkg::FRIC_WET_MUD    : hbs_pkg::FRIC_DRY_MUD;
                default:
                    return w ? hbs_pkg::FRIC_WET_OTHER  : hbs_pkg::FRIC_DRY_OTHER;
            endcase
        endfunction

        function void note_word(logic c, logic [hbs_pkg::CELL_INDEX_W-1:0] idx,
                                logic signed [hbs_pkg::ELEV_W-1:0] e,
                                logic [hbs_pkg::CLASS_W-1:0] k,
                                logic signed [hbs_pkg::COORD_W-1:0] qx,
                                logic signed [hbs_pkg::COORD_W-1:0] qz, logic w);
            logic [31:0] gx, gz;
            int unsigned x0, x1, z0, z1;
            longint v0, v1;
            sample_t s;
            if (c == hbs_pkg::CMD_WRITE)
            begin
                if (idx < CELLS)
                begin
                    elev_grid[idx] = e;
                    class_grid[idx] = k;
                end
                return;
            end
            gx = grid_pos(qx);
            gz = grid_pos(qz);
            x0 = gx >> 16;
            z0 = gz >> 16;
            x1 = (x0 + 1 < SIDE) ? x0 + 1 : SIDE - 1;
            z1 = (z0 + 1 < SIDE) ? z0 + 1 : SIDE - 1;
            v0 = lerp(height(z0, x0), height(z0, x1), gx[15:0]);
            v1 = lerp(height(z1, x0), height(z1, x1), gx[15:0]);
            s.elev = 32'(lerp(v0, v1, gz[15:0]));
            s.cls = class_grid[nearest(gz) * SIDE + nearest(gx)];
            s.fric = grip(s.cls, w);
            pending_q = {pending_q, s};
        endfunction

        function void check_word(logic signed [hbs_pkg::ELEV_W-1:0] e,
                                 logic [hbs_pkg::CLASS_W-1:0] k,
                                 logic [hbs_pkg::FRIC_W-1:0] f);
            sample_t s;
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected sample word elevation %0d", $time, e);
                errors++;
                return;
            end
            s = pending_q.pop_front();
            if (e !== s.elev)
            begin
                $display("%0t: elevation expected %0d actual %0d", $time, s.elev, e);
                errors++;
            end
            if (k !== s.cls)
            begin
                $display("%0t: surface_class expected %0d actual %0d", $time, s.cls, k);
                errors++;
            end
            if (f !== s.fric)
            begin
                $display("%0t: friction expected %0d actual %0d", $time, s.fric, f);
                errors++;
            end
        endfunction
    endclass

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                start = 1'b0;
    logic                                busy;
    logic                                cmd = hbs_pkg::CMD_WRITE;
    logic [hbs_pkg::CELL_INDEX_W-1:0]    cell_index = '0;
    logic signed [hbs_pkg::ELEV_W-1:0]   cell_elevation = '0;
    logic [hbs_pkg::CLASS_W-1:0]         cell_class = '0;
    logic signed [hbs_pkg::COORD_W-1:0]  query_x = '0;
    logic signed [hbs_pkg::COORD_W-1:0]  query_z = '0;
    logic                                wet = 1'b0;
    logic                                done;
    logic signed [hbs_pkg::ELEV_W-1:0]   elevation;
    logic [hbs_pkg::CLASS_W-1:0]         surface_class;
    logic [hbs_pkg::FRIC_W-1:0]          friction;

    sample_scoreboard sb;
    bit               quiet_stretch;

    heightmap_bilinear_sampler dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .cell_index(cell_index), .cell_elevation(cell_elevation),
        .cell_class(cell_class), .query_x(query_x), .query_z(query_z), .wet(wet),
        .done(done), .elevation(elevation), .surface_class(surface_class),
        .friction(friction)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_word(elevation, surface_class, friction);
    end

    task automatic send_word(logic c, logic [hbs_pkg::CELL_INDEX_W-1:0] idx,
                             logic signed [hbs_pkg::ELEV_W-1:0] e,
                             logic [hbs_pkg::CLASS_W-1:0] k,
                             logic signed [hbs_pkg::COORD_W-1:0] qx,
                             logic signed [hbs_pkg::COORD_W-1:0] qz, logic w);
        int gap;
        start          <= 1'b1;
        cmd            <= c;
        cell_index     <= idx;
        cell_elevation <= e;
        cell_class     <= k;
        query_x        <= qx;
        query_z        <= qz;
        wet            <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_word(c, idx, e, k, qx, qz, w);
        gap = 0;
        if (!quiet_stretch)
        begin
            case ($urandom_range(19))
                0, 1, 2, 3: gap = int'($urandom_range(3, 1));
                4:          gap = int'($urandom_range(30, 8));
                default:    gap = 0;
            endcase
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_cell(int idx, logic signed [hbs_pkg::ELEV_W-1:0] e,
                              logic [hbs_pkg::CLASS_W-1:0] k);
        send_word(hbs_pkg::CMD_WRITE, hbs_pkg::CELL_INDEX_W'(idx), e, k, $urandom, $urandom,
                  1'($urandom_range(1)));
    endtask

    task automatic sample(logic signed [hbs_pkg::COORD_W-1:0] qx,
                          logic signed [hbs_pkg::COORD_W-1:0] qz, logic w);
        send_word(hbs_pkg::CMD_SAMPLE, hbs_pkg::CELL_INDEX_W'($urandom), $urandom,
                  hbs_pkg::CLASS_W'($urandom), qx, qz, w);
    endtask

    // Samples stay where bands of BAND rows and BAND columns at the grid edges cross,
    // and every cell where two such bands cross is written before the first sample.
    function automatic int band_at(int k);
        return (k < BAND) ? k : SIDE - 2 * BAND + k;
    endfunction

    function automatic logic signed [hbs_pkg::COORD_W-1:0] rand_coord();
        if ($urandom_range(1) == 0)
        begin
            case ($urandom_range(5))
                0:       return {1'b1, 31'($urandom)};
                1:       return 0;
                2:       return 32'($urandom_range(BAND - 2) * STEP);
                3:       return 32'($urandom_range(BAND - 2) * STEP + STEP / 2);
                4:       return 32'($urandom_range(3));
                default: return 32'($urandom_range((BAND - 1) * STEP - 1));
            endcase
        end
        else
        begin
            case ($urandom_range(5))
                0:       return hbs_pkg::ONE_Q16;
                1:       return 32'($urandom_range(32'h7FFF_FFFF, hbs_pkg::ONE_Q16 + 1));
                2:       return 32'((SIDE - BAND + $urandom_range(BAND - 1)) * STEP);
                3:       return 32'((SIDE - BAND + $urandom_range(BAND - 2)) * STEP + STEP / 2);
                4:       return 32'(hbs_pkg::ONE_Q16 - 1);
                default: return 32'($urandom_range(hbs_pkg::ONE_Q16, (SIDE - BAND) * STEP));
            endcase
        end
    endfunction

    function automatic logic signed [hbs_pkg::ELEV_W-1:0] rand_elev();
        case ($urandom_range(5))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return 32'(int'($urandom_range(65536 * 200)) - 65536 * 100);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [hbs_pkg::CLASS_W-1:0] rand_class();
        return ($urandom_range(2) == 0) ? hbs_pkg::CLASS_W'($urandom_range(255))
                                        : hbs_pkg::CLASS_W'($urandom_range(4));
    endfunction

    initial
    begin
        int wait_cycles;
        sb = new();
        quiet_stretch = 1'b1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int zi = 0; zi < 2 * BAND; zi++)
            for (int xi = 0; xi < 2 * BAND; xi++)
                write_cell(band_at(zi) * SIDE + band_at(xi), rand_elev(), rand_class());

        quiet_stretch = 1'b0;
        write_cell(0, 32'sh7FFF_FFFF, hbs_pkg::CLASS_PAVED);
        write_cell(1, 32'sh8000_0000, hbs_pkg::CLASS_GRAVEL);
        write_cell(SIDE, 32'sh8000_0000, hbs_pkg::CLASS_DIRT);
        write_cell(SIDE + 1, 32'sh7FFF_FFFF, hbs_pkg::CLASS_MUD);
        write_cell(CELLS - 1, 32'sh0001_0000, 8'd255);
        write_cell(CELLS, 32'sh1234_5678, 8'd7);
        write_cell(13'h1FFF, 32'sh7654_3210, 8'd9);
        sample(0, 0, 1'b0);
        sample(0, 0, 1'b1);
        sample(32'sh8000_0000, 32'sh8000_0000, 1'b1);
        sample(512, 0, 1'b0);
        sample(0, 512, 1'b1);
        sample(511, 511, 1'b0);
        sample(1023, 1023, 1'b1);
        sample(hbs_pkg::ONE_Q16, hbs_pkg::ONE_Q16, 1'b0);
        sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
        sample(32'sh0001_0001, 32'shFFFF_FFFF, 1'b0);
        sample(1, 1, 1'b1);
        sample(hbs_pkg::ONE_Q16 - 1, hbs_pkg::ONE_Q16 - 1, 1'b0);
        sample(700, 300, 1'b0);
        sample(300, 700, 1'b1);
        write_cell(2, 32'sh0000_0000, 8'd4);
        sample(1024, 0, 1'b0);
        sample(1024, 0, 1'b1);

        for (int n = 0; n < 240; n++)
        begin
            if (n % 50 == 0)
                quiet_stretch = ($urandom_range(3) == 0);
            if ($urandom_range(2) == 0)
            begin
                if ($urandom_range(9) == 0)
                    write_cell(int'($urandom_range(13'h1FFF)), rand_elev(), rand_class());
                else
                    write_cell(band_at(int'($urandom_range(2 * BAND - 1))) * SIDE +
                               band_at(int'($urandom_range(2 * BAND - 1))),
                               rand_elev(), rand_class());
            end
            else
            begin
                sample(rand_coord(), rand_coord(), 1'($urandom_range(1)));
            end
        end
        start <= 1'b0;

        wait_cycles = 0;
        while (sb.pending_q.size() != 0 && wait_cycles < 1000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (12) @(posedge clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("heightmap_bilinear_sampler_tb: PASS");
        else
            $display("heightmap_bilinear_sampler_tb: FAIL");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("heightmap_bilinear_sampler_tb: FAIL");
        $finish;
    end

endmodule
